/* rtl/pglide_pkg.sv */
// ----------------------------------------------------------------------------
// pglide_pkg
// Shared widths, action codes and control structs for the pitch glide block.
// ----------------------------------------------------------------------------
package pglide_pkg;

    localparam int KEY_W          = 16;
    localparam int SAMPLES_W      = 20;
    localparam int ACTION_W       = 3;
    localparam int GLIDE_BITS_DEF = 20;
    localparam int DIST_W         = KEY_W + 1;
    localparam int CNT_W          = $clog2(KEY_W);

    localparam logic [KEY_W-1:0] DEFAULT_KEY_RST = 16'd24576;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK      = 3'd0,
        ACT_NEW_KEY   = 3'd1,
        ACT_KEY_ON    = 3'd2,
        ACT_SET_LEN   = 3'd3,
        ACT_RESET_KEY = 3'd4
    } t_action;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input word
        logic decode;    // classify action, step glide position
        logic mul;       // distance * position, seed divider
        logic div_step;  // one restoring divide step
        logic commit;    // update key state, load output word
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic glide_tick;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

/* rtl/pglide_ctrl.sv */
// ----------------------------------------------------------------------------
// pglide_ctrl
// Sequencer: accept, decode, multiply and serial divide (gliding ticks only), write back.
// ----------------------------------------------------------------------------
module pglide_ctrl
    import pglide_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_MUL    = 5'b00100,
        S_DIV    = 5'b01000,
        S_WRITE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = i_status.glide_tick ? S_MUL : S_WRITE;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/pglide_dp.sv */
// ----------------------------------------------------------------------------
// pglide_dp
// Key state, glide multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
module pglide_dp
    import pglide_pkg::*;
#(
    parameter int GLIDE_BITS = GLIDE_BITS_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [ACTION_W-1:0]  i_action,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [SAMPLES_W-1:0] i_glide_samples,
    input  logic                 i_cfg_we,
    input  logic [KEY_W-1:0]     i_cfg_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [KEY_W-1:0]     o_current_key
);

    localparam int PROD_W = KEY_W + GLIDE_BITS;

    // captured input word
    logic [ACTION_W-1:0]   r_action;
    logic [KEY_W-1:0]      r_key;
    logic [SAMPLES_W-1:0]  r_samples;

    // key state
    logic [KEY_W-1:0]      r_def_key;
    logic [KEY_W-1:0]      r_now;
    logic [KEY_W-1:0]      r_start;
    logic [DIST_W-1:0]     r_dist;
    logic [GLIDE_BITS-1:0] r_pos;
    logic [GLIDE_BITS-1:0] r_len;
    logic                  r_is_glide;

    // divider
    logic [GLIDE_BITS-1:0] r_rem;
    logic [KEY_W-1:0]      r_dvd;
    logic [CNT_W-1:0]      r_cnt;

    // output word
    logic                  r_out_valid;
    logic [KEY_W-1:0]      r_out_key;

    logic [DIST_W-1:0]           dist_abs;
    logic [PROD_W-1:0]           prod;
    logic [GLIDE_BITS:0]         trial;
    logic [GLIDE_BITS:0]         trial_diff;
    logic                        trial_ge;
    logic [KEY_W-1:0]            target;
    logic [KEY_W-1:0]            step;
    logic [KEY_W-1:0]            glide_key;
    logic [SAMPLES_W+GLIDE_BITS-1:0] samples_ext;
    logic [GLIDE_BITS-1:0]       samples_len;
    logic                        glide_on;

    assign glide_on = (r_len != '0) && (r_dist != '0);

    assign o_status.glide_tick = (r_action == ACT_TICK) && glide_on && (r_pos < r_len);
    assign o_status.div_last   = (r_cnt == CNT_W'(KEY_W - 1));
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // |distance| fits 16 bits
    assign dist_abs = r_dist[DIST_W-1] ? (DIST_W'(0) - r_dist) : r_dist;
    assign prod     = PROD_W'(dist_abs[KEY_W-1:0]) * PROD_W'(r_pos);

    assign trial      = {r_rem, r_dvd[KEY_W-1]};
    assign trial_ge   = (trial >= {1'b0, r_len});
    assign trial_diff = trial - {1'b0, r_len};

    assign target    = r_start + r_dist[KEY_W-1:0];
    // negative glide rounds the step up
    assign step      = r_dvd + KEY_W'(r_dist[DIST_W-1] && (r_rem != '0));
    assign glide_key = r_dist[DIST_W-1] ? (r_start - step) : (r_start + step);

    assign samples_ext = {{GLIDE_BITS{1'b0}}, r_samples};
    assign samples_len = samples_ext[GLIDE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action  <= i_action;
            r_key     <= i_key;
            r_samples <= i_glide_samples;
        end
        if (i_cmd.mul) begin
            r_rem <= prod[PROD_W-1:KEY_W];
            r_dvd <= prod[KEY_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? trial_diff[GLIDE_BITS-1:0] : trial[GLIDE_BITS-1:0];
            r_dvd <= {r_dvd[KEY_W-2:0], trial_ge};
        end
        if (i_cmd.commit) begin
            case (r_action)
                ACT_TICK:      r_out_key <= r_is_glide ? glide_key : target;
                ACT_KEY_ON:    r_out_key <= target;
                ACT_RESET_KEY: r_out_key <= r_def_key;
                default:       r_out_key <= r_now;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_key   <= DEFAULT_KEY_RST;
            r_now       <= DEFAULT_KEY_RST;
            r_start     <= DEFAULT_KEY_RST;
            r_dist      <= '0;
            r_pos       <= '0;
            r_len       <= '0;
            r_is_glide  <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_def_key <= i_cfg_data;
            end
            if (i_cmd.decode) begin
                r_is_glide <= o_status.glide_tick;
                if (o_status.glide_tick) begin
                    r_pos <= r_pos + GLIDE_BITS'(1);
                end
            end
            if (i_cmd.mul) begin
                r_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.commit) begin
                case (r_action)
                    ACT_TICK: begin
                        if (r_is_glide) begin
                            r_now <= glide_key;
                        end else begin
                            r_now <= target;
                            if (glide_on) begin
                                r_start <= target;
                                r_dist  <= '0;
                            end
                        end
                    end
                    ACT_NEW_KEY: begin
                        r_start <= r_now;
                        r_dist  <= {1'b0, r_key} - {1'b0, r_now};
                        r_pos   <= '0;
                    end
                    ACT_KEY_ON: begin
                        r_now   <= target;
                        r_start <= target;
                        r_dist  <= '0;
                    end
                    ACT_SET_LEN: begin
                        r_len <= samples_len;
                    end
                    ACT_RESET_KEY: begin
                        r_now   <= r_def_key;
                        r_start <= r_def_key;
                        r_dist  <= '0;
                    end
                    default: begin
                        r_now <= r_now;
                    end
                endcase
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_current_key = r_out_key;

endmodule

/* rtl/portamento_key_glide_top.sv */
// ----------------------------------------------------------------------------
// portamento_key_glide_top
// Linear portamento for one synth voice: one action word in, one key word out.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                  payload
//  -------   ---  -------------------------  ----------------------------------
//  in        in   i_in_valid / o_in_stall    i_action, i_key, i_glide_samples
//  out       out  o_out_valid / i_out_stall  o_current_key
//  cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_data (default key)
//
//  Sequence: a gliding tick runs accept, decode, multiply, 16 restoring
//  divide steps and write back; any other word runs accept, decode and
//  write back. The divide loop retires one quotient bit a cycle.
//  Reset: synchronous, active low; key state returns to the default key,
//  glide length/position/distance clear, default key register to 24576.
//  Stalls: the output register holds a finished word while the next input
//  word is accepted; write back waits only if that register is still full.
// ----------------------------------------------------------------------------
module portamento_key_glide_top
    import pglide_pkg::*;
#(
    parameter int GLIDE_BITS = GLIDE_BITS_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input words
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ACTION_W-1:0]  i_action,
    input  logic [KEY_W-1:0]     i_key,
    input  logic [SAMPLES_W-1:0] i_glide_samples,
    // result words
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [KEY_W-1:0]     o_current_key,
    // default key register
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [KEY_W-1:0]     i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // register accepts at any time; software must write only when idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;

    pglide_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // key = start + floor(dist*pos/len); a falling glide rounds its step up,
    // so the key rounds down in both directions
    pglide_dp #(
        .GLIDE_BITS (GLIDE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_action        (i_action),
        .i_key           (i_key),
        .i_glide_samples (i_glide_samples),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_current_key   (o_current_key)
    );

endmodule

/* rtl/pglide_chk.sv */
// ----------------------------------------------------------------------------
// pglide_chk
// Port-level checks for the pitch glide block, bound to the top level.
// ----------------------------------------------------------------------------
module pglide_chk
    import pglide_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [KEY_W-1:0] o_current_key
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_current_key))
        else $error("result word changed under stall");

    // one word in work at a time
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a word is in work");

    // input reopens only as the result is written back
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_stall) |-> o_out_valid)
        else $error("input reopened without a result");

    // no result invented while idle
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a word in work");

endmodule

bind portamento_key_glide_top pglide_chk u_pglide_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_current_key (o_current_key)
);
